### sv/srt_pkg.sv
// Shared widths, constants and unit interface types for the SRTF scheduler.
package srt_pkg;

  localparam int unsigned SRT_MAX_PROCS = 16;
  localparam int unsigned SRT_TIME_BITS = 13;

  localparam int unsigned BURST_W    = 8;
  localparam int unsigned ARR_W      = 10;
  localparam int unsigned OUT_IDX_W  = 4;
  localparam int unsigned OUT_TIME_W = 13;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [OUT_TIME_W-1:0] OUT_TIME_MAX = 13'd8191;

  // Control into the shared update/compare unit.
  typedef struct packed {
    logic upd_en;   // apply the previous tick's run/wait update
    logic is_pick;  // this entry ran in the previous tick
    logic found;    // a candidate already exists in this pass
  } alu_ctl_t;

  // Status back from the unit.
  typedef struct packed {
    logic unfinished;  // remaining burst nonzero after update
    logic take;        // entry becomes the new best candidate
  } alu_sts_t;

endpackage

### sv/srt_mem.sv
// Process table: one write port, one registered read port.
module srt_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 44,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/srt_alu.sv
// Shared per-entry unit: applies last tick's update, then compares for this tick.
module srt_alu #(
  parameter int unsigned TIME_BITS = 13
) (
  input  srt_pkg::alu_ctl_t             ctl_i,
  input  logic [srt_pkg::BURST_W-1:0]   rem_i,
  input  logic [srt_pkg::ARR_W-1:0]     arr_i,
  input  logic [TIME_BITS-1:0]          wait_i,
  input  logic [TIME_BITS-1:0]          tat_i,
  input  logic [TIME_BITS-1:0]          tprev_i,
  input  logic [TIME_BITS-1:0]          tcur_i,
  input  logic [srt_pkg::BURST_W-1:0]   best_i,
  output logic [srt_pkg::BURST_W-1:0]   rem_o,
  output logic [TIME_BITS-1:0]          wait_o,
  output logic [TIME_BITS-1:0]          tat_o,
  output srt_pkg::alu_sts_t             sts_o
);
  import srt_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  logic [CMP_W-1:0] arr_x;
  logic [CMP_W-1:0] tprev_x;
  logic [CMP_W-1:0] tcur_x;

  assign arr_x   = CMP_W'(arr_i);
  assign tprev_x = CMP_W'(tprev_i);
  assign tcur_x  = CMP_W'(tcur_i);

  always_comb begin
    rem_o  = rem_i;
    wait_o = wait_i;
    tat_o  = tat_i;
    if (ctl_i.upd_en) begin
      if (ctl_i.is_pick) begin
        rem_o = rem_i - BURST_W'(1);
        if (rem_o == '0) begin
          tat_o = (tcur_x >= arr_x) ? TIME_BITS'(tcur_x - arr_x) : '0;
        end
      end else if ((rem_i != '0) && (arr_x <= tprev_x)) begin
        wait_o = (&wait_i) ? wait_i : wait_i + TIME_BITS'(1);
      end
    end
    sts_o.unfinished = (rem_o != '0);
    sts_o.take       = sts_o.unfinished && (arr_x <= tcur_x) &&
                       (!ctl_i.found || (rem_o < best_i));
  end

endmodule

### sv/shortest_remaining_time_sim.sv
// Top level: load, tick-by-tick SRTF simulation and result readout.
//
// Use: processes stream in on the s_axis channel, one item each, tdata
// holding burst_time and arrival_time, tlast marking the final process.
// Items beyond MAX_PROCS are dropped (a dropped item with tlast still
// starts the run). s_axis_tready is high only while loading, and stays
// high for the whole of it.
// After the last item the block simulates preemptive SRTF from time 0.
// One simulated tick is one pass over the N stored processes through a
// single read port and one shared update/compare unit: N reads, the last
// read's data, then the tick decision. The pass writes back the
// previous tick's run/wait update while it searches for the next pick.
// Results then leave on m_axis, one per process in load order; each is
// read into the output register only once the previous one is taken.
// A stalled receiver holds the output register and the readout simply
// waits. tlast marks the result of the final process, after which
// loading starts again.
// Reset (rst_ni low, asynchronous) empties the set and returns to
// loading; the table itself is not cleared, only entries just loaded
// are ever read.
module shortest_remaining_time_sim #(
  parameter int unsigned MAX_PROCS = srt_pkg::SRT_MAX_PROCS,
  parameter int unsigned TIME_BITS = srt_pkg::SRT_TIME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] burst_time, [17:8] arrival_time, [23:18] zero
  input  logic [srt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,   // last_process
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] process_index, [16:4] wait_time, [29:17] turnaround_time, [31:30] zero
  output logic [srt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast    // last_result
);
  import srt_pkg::*;

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned MEM_W = BURST_W + ARR_W + 2 * TIME_BITS;
  localparam int unsigned WAIT_LO = TIME_BITS;
  localparam int unsigned ARR_LO  = 2 * TIME_BITS;
  localparam int unsigned REM_LO  = 2 * TIME_BITS + ARR_W;
  localparam int unsigned CL_W = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;
  localparam int unsigned PAD_W = OUT_DATA_W - OUT_IDX_W - 2 * OUT_TIME_W;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_TICK = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;        // processes in the set
  logic [CNT_W-1:0]      ra_q;         // next read address
  logic                  vld_q;        // read data valid this cycle
  logic [IDX_W-1:0]      idx_q;        // entry of the read data
  logic                  upd_en_q;     // previous tick ran a process
  logic [IDX_W-1:0]      pick_prev_q;
  logic [TIME_BITS-1:0]  tprev_q;
  logic [TIME_BITS-1:0]  tcur_q;       // time of the tick being searched
  logic                  found_q;
  logic                  unf_q;        // any unfinished process seen
  logic [BURST_W-1:0]    best_q;
  logic [IDX_W-1:0]      pick_q;

  logic                  m_valid_q;
  logic [OUT_IDX_W-1:0]  out_idx_q;
  logic [OUT_TIME_W-1:0] out_wait_q;
  logic [OUT_TIME_W-1:0] out_tat_q;
  logic                  out_last_q;

  logic                  in_acc;
  logic                  out_acc;
  logic                  room;
  logic                  pass_end;
  logic                  idx_last;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;
  logic                  mem_re;
  logic [MEM_W-1:0]      mem_rdata;

  logic [BURST_W-1:0]    rd_rem;
  logic [ARR_W-1:0]      rd_arr;
  logic [TIME_BITS-1:0]  rd_wait;
  logic [TIME_BITS-1:0]  rd_tat;
  logic [BURST_W-1:0]    up_rem;
  logic [TIME_BITS-1:0]  up_wait;
  logic [TIME_BITS-1:0]  up_tat;
  logic [OUT_TIME_W-1:0] wait_clamp;
  logic [OUT_TIME_W-1:0] tat_clamp;
  alu_ctl_t              alu_ctl;
  alu_sts_t              alu_sts;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_valid_q && m_axis_tready;
  assign room          = (cnt_q < CNT_W'(MAX_PROCS));
  assign idx_last      = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
  assign pass_end      = vld_q && idx_last;

  // table entry: {remaining, arrival, wait, turnaround}
  assign rd_rem  = mem_rdata[REM_LO +: BURST_W];
  assign rd_arr  = mem_rdata[ARR_LO +: ARR_W];
  assign rd_wait = mem_rdata[WAIT_LO +: TIME_BITS];
  assign rd_tat  = mem_rdata[0 +: TIME_BITS];

  // read issue: every cycle during a scan, one at a time during readout
  always_comb begin
    mem_re = 1'b0;
    if (ra_q < cnt_q) begin
      if (state_q == ST_SCAN) begin
        mem_re = 1'b1;
      end else if (state_q == ST_OUT) begin
        mem_re = !m_valid_q && !vld_q;
      end
    end
  end

  // write port: load stores a fresh entry, scan writes back the update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {up_rem, rd_arr, up_wait, up_tat};
    if (state_q == ST_LOAD) begin
      mem_we    = in_acc && room;
      mem_waddr = cnt_q[IDX_W-1:0];
      mem_wdata = {s_axis_tdata[0 +: BURST_W], s_axis_tdata[BURST_W +: ARR_W],
                   {(2 * TIME_BITS){1'b0}}};
    end else if (state_q == ST_SCAN) begin
      mem_we = vld_q;
    end
  end

  srt_mem #(
    .DEPTH (MAX_PROCS),
    .WIDTH (MEM_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ra_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign alu_ctl.upd_en  = upd_en_q;
  assign alu_ctl.is_pick = (idx_q == pick_prev_q);
  assign alu_ctl.found   = found_q;

  srt_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .ctl_i   (alu_ctl),
    .rem_i   (rd_rem),
    .arr_i   (rd_arr),
    .wait_i  (rd_wait),
    .tat_i   (rd_tat),
    .tprev_i (tprev_q),
    .tcur_i  (tcur_q),
    .best_i  (best_q),
    .rem_o   (up_rem),
    .wait_o  (up_wait),
    .tat_o   (up_tat),
    .sts_o   (alu_sts)
  );

  // reported times stop at the output field's maximum
  assign wait_clamp = (CL_W'(rd_wait) > CL_W'(OUT_TIME_MAX)) ? OUT_TIME_MAX
                                                             : OUT_TIME_W'(rd_wait);
  assign tat_clamp  = (CL_W'(rd_tat) > CL_W'(OUT_TIME_MAX)) ? OUT_TIME_MAX
                                                            : OUT_TIME_W'(rd_tat);

  // read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      idx_q <= ra_q[IDX_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      ra_q      <= '0;
      upd_en_q  <= 1'b0;
      found_q   <= 1'b0;
      unf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (mem_re) begin
        ra_q <= ra_q + CNT_W'(1);
      end
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              state_q  <= ST_SCAN;
              ra_q     <= '0;
              upd_en_q <= 1'b0;
              found_q  <= 1'b0;
              unf_q    <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (vld_q) begin
            if (alu_sts.unfinished) begin
              unf_q <= 1'b1;
            end
            if (alu_sts.take) begin
              found_q <= 1'b1;
            end
          end
          if (pass_end) begin
            state_q <= ST_TICK;
          end
        end
        ST_TICK: begin
          ra_q <= '0;
          if (!unf_q) begin
            state_q  <= ST_OUT;
            upd_en_q <= 1'b0;
          end else begin
            // commit this tick's choice; its effects land in the next pass
            state_q  <= ST_SCAN;
            upd_en_q <= found_q;
            found_q  <= 1'b0;
            unf_q    <= 1'b0;
          end
        end
        ST_OUT: begin
          if (vld_q) begin
            m_valid_q <= 1'b1;
          end else if (out_acc) begin
            m_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= ST_LOAD;
              cnt_q   <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // tick datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      tcur_q <= '0;
    end else if (state_q == ST_TICK) begin
      pick_prev_q <= pick_q;
      tprev_q     <= tcur_q;
      tcur_q      <= (&tcur_q) ? tcur_q : tcur_q + TIME_BITS'(1);
    end
    if ((state_q == ST_SCAN) && vld_q && alu_sts.take) begin
      best_q <= up_rem;
      pick_q <= idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && vld_q) begin
      out_idx_q  <= OUT_IDX_W'(idx_q);
      out_wait_q <= wait_clamp;
      out_tat_q  <= tat_clamp;
      out_last_q <= idx_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_tat_q, out_wait_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // the set never grows past the table
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PROCS))
    else $error("process count beyond table depth");

  // a committed pick always names a stored process
  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en_q |-> (CNT_W'(pick_prev_q) < cnt_q))
    else $error("pick outside loaded set");

  // results only appear during readout
  a_out_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (state_q == ST_OUT))
    else $error("result valid outside readout");

  // read data never arrives while loading or deciding a tick
  a_rd_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == ST_SCAN || state_q == ST_OUT))
    else $error("table read outside scan or readout");

  // the last result ends readout and reopens loading
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_q) |=> (state_q == ST_LOAD && cnt_q == '0))
    else $error("readout did not close after last result");
`endif

endmodule
